/* hdl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg: shared widths and types for point_segment_distance
// Coordinate, product and root widths plus the record passed down the
// square-root cell chain.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int DIST_BITS  = 17;

    // difference, product, sum-of-products widths (signed)
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SUMW = PW + 1;
    // numerator (cross^2) and scaled remainder widths (unsigned)
    localparam int NUMW = 2 * SUMW;
    localparam int REMW = NUMW + 2 * FRAC_BITS;
    // r * den and trial-subtrahend widths
    localparam int RDW  = SUMW + DIST_BITS;
    localparam int TRW  = SUMW + 2 * DIST_BITS + 1;
    localparam int CMPW = (TRW > REMW) ? TRW : REMW;
    localparam int IDXW = $clog2(DIST_BITS);

    typedef struct packed {
        logic                 valid;
        logic [REMW-1:0]      rem;
        logic [RDW-1:0]       rden;
        logic [SUMW-1:0]      den;
        logic [DIST_BITS-1:0] root;
        logic                 oor;
        logic                 degen;
    } cell_data_t;

endpackage

/* hdl/point_segment_distance.sv */
// ----------------------------------------------------------------------------
// point_segment_distance: perpendicular point-to-segment distance
// Four setup stages feed a chain of 17 root cells, one result bit each.
//
//   channel | signals                                | direction
//   input   | in_valid, in_stall, point/start/end xy | into block
//   output  | out_valid, out_stall, dist_q4, flags   | out of block
//
// One transfer per cycle sustained while no result is held by out_stall.
// Throughput is set by the whole pipeline advancing as one shift line.
// Reset clears only the valid bits of every stage.
// An output stall while a result is held freezes every stage; in_stall is raised at once.
// ----------------------------------------------------------------------------
module point_segment_distance (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [psd_pkg::DIST_BITS-1:0]         dist_q4,
    output logic                                  off_segment,
    output logic                                  degenerate
);
    import psd_pkg::*;

    logic       en;
    cell_data_t chain [DIST_BITS+1];

    // pipeline moves whenever the output slot is empty or taken
    assign en       = !chain[DIST_BITS].valid || !out_stall;
    assign in_stall = !en;

    psd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .point_x  (point_x),
        .point_y  (point_y),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .head     (chain[0])
    );

    // root bits from most significant down
    for (genvar i = 0; i < DIST_BITS; i++)
    begin : g_cell
        psd_root_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .bit_idx (IDXW'(DIST_BITS - 1 - i)),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    assign out_valid   = chain[DIST_BITS].valid;
    assign dist_q4     = chain[DIST_BITS].root;
    assign off_segment = chain[DIST_BITS].oor;
    assign degenerate  = chain[DIST_BITS].degen;

endmodule

/* hdl/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front: vector setup stages
// Differences, products, dot/cross/len2 and the radicand numerator/denominator
// over four registered stages.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_y,
    output psd_pkg::cell_data_t                  head
);
    import psd_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PW-1:0] bxbx_reg, byby_reg, bxax_reg, byay_reg;
    logic signed [PW-1:0] byax_reg, bxay_reg, axax_reg, ayay_reg;
    logic                 degen2_reg, degen3_reg, oor3_reg;
    logic signed [SUMW-1:0] len2_reg, ssq_reg;
    logic [SUMW-1:0]      cabs_reg;
    logic signed [SUMW-1:0] len2_c, dot_c, cross_c, ssq_c;
    logic [NUMW-1:0]      num_c;
    cell_data_t           head_reg;

    // stage 3 sums
    always_comb
    begin
        len2_c  = SUMW'(bxbx_reg) + SUMW'(byby_reg);
        dot_c   = SUMW'(bxax_reg) + SUMW'(byay_reg);
        cross_c = SUMW'(byax_reg) - SUMW'(bxay_reg);
        ssq_c   = SUMW'(axax_reg) + SUMW'(ayay_reg);
    end

    // stage 4 numerator: cross squared, point distance squared, or zero
    always_comb
    begin
        if (degen3_reg)
            num_c = NUMW'($unsigned(ssq_reg));
        else if (oor3_reg)
            num_c = '0;
        else
            num_c = NUMW'(cabs_reg) * NUMW'(cabs_reg);
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= DW'(point_x) - DW'(start_x);
            ay_reg <= DW'(point_y) - DW'(start_y);
            bx_reg <= DW'(end_x) - DW'(start_x);
            by_reg <= DW'(end_y) - DW'(start_y);

            bxbx_reg   <= bx_reg * bx_reg;
            byby_reg   <= by_reg * by_reg;
            bxax_reg   <= bx_reg * ax_reg;
            byay_reg   <= by_reg * ay_reg;
            byax_reg   <= by_reg * ax_reg;
            bxay_reg   <= bx_reg * ay_reg;
            axax_reg   <= ax_reg * ax_reg;
            ayay_reg   <= ay_reg * ay_reg;
            degen2_reg <= (bx_reg == '0) && (by_reg == '0);

            len2_reg   <= len2_c;
            ssq_reg    <= ssq_c;
            cabs_reg   <= cross_c[SUMW-1] ? SUMW'(-cross_c) : SUMW'(cross_c);
            degen3_reg <= degen2_reg;
            oor3_reg   <= !degen2_reg && (dot_c < 0 || dot_c > len2_c);

            head_reg.valid <= v3_reg;
            head_reg.rem   <= REMW'(num_c) << (2 * FRAC_BITS);
            head_reg.rden  <= '0;
            head_reg.den   <= degen3_reg ? SUMW'(1) : SUMW'($unsigned(len2_reg));
            head_reg.root  <= '0;
            head_reg.oor   <= oor3_reg;
            head_reg.degen <= degen3_reg;
        end
    end

    always_comb
    begin
        head       = head_reg;
        head.valid = v4_reg;
    end

endmodule

/* hdl/psd_root_cell.sv */
// ----------------------------------------------------------------------------
// psd_root_cell: one bit of the ratio square root
// Tries root bit bit_idx: keeps rem = num*4^F - r^2*den and rden = r*den,
// so the trial needs only shifts, one add and one compare.
// ----------------------------------------------------------------------------
module psd_root_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [psd_pkg::IDXW-1:0]  bit_idx,
    input  psd_pkg::cell_data_t       din,
    output psd_pkg::cell_data_t       dout
);
    import psd_pkg::*;

    logic [CMPW-1:0] trial_c;
    logic            take_c;
    cell_data_t      dout_reg;
    logic            valid_reg;

    // (r + 2^k)^2 * den - r^2 * den = r*den*2^(k+1) + den*4^k
    always_comb
    begin
        trial_c = (CMPW'(din.rden) << (bit_idx + 1'b1)) + (CMPW'(din.den) << (2 * bit_idx));
        take_c  = trial_c <= CMPW'(din.rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= din;
            if (take_c)
            begin
                dout_reg.rem  <= din.rem - REMW'(trial_c);
                dout_reg.rden <= din.rden + (RDW'(din.den) << bit_idx);
                dout_reg.root <= din.root | (DIST_BITS'(1) << bit_idx);
            end
        end
    end

    always_comb
    begin
        dout       = dout_reg;
        dout.valid = valid_reg;
    end

endmodule

/* hdl/psd_checker.sv */
// ----------------------------------------------------------------------------
// psd_checker: port-level checks for point_segment_distance
// Flag consistency and stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [psd_pkg::DIST_BITS-1:0] dist_q4,
    input logic                          off_segment,
    input logic                          degenerate
);
    import psd_pkg::*;

    // an off-segment transfer carries no distance
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && off_segment |-> dist_q4 == '0)
        else $error("off_segment with nonzero distance");

    // a zero-length segment always projects inside
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(off_segment && degenerate))
        else $error("both flags set");

    // input is held back exactly while a result waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow output stall");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dist_q4)
            && $stable(off_segment) && $stable(degenerate))
        else $error("stalled result changed");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dist_q4     (dist_q4),
    .off_segment (off_segment),
    .degenerate  (degenerate)
);

/* verif/point_segment_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_tb: self-checking bench for point_segment_distance
// Drives directed and random point/segment transfers with random idle and
// stall cycles, predicts distance and flags with exact integer math, and
// compares every output transfer in order.
// ----------------------------------------------------------------------------
module point_segment_distance_tb;

    localparam int CW       = psd_pkg::COORD_BITS;
    localparam int DB       = psd_pkg::DIST_BITS;
    localparam int NUM_RAND = 750;

    typedef struct packed {
        logic [CW-1:0] px, py, sx, sy, ex, ey;
    } seg_query_t;

    typedef struct packed {
        logic [DB-1:0] dist_val;
        logic          oor;
        logic          degen;
    } seg_answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
    logic out_valid;
    logic out_stall;
    logic [DB-1:0] dist_q4;
    logic off_segment;
    logic degenerate;

    seg_query_t  pending_q[$];
    seg_answer_t answer_q[$];
    int          err_count;
    int          cycle_count;
    bit          stim_done;

    point_segment_distance i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y),
        .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .dist_q4(dist_q4), .off_segment(off_segment), .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // largest r <= max with r^2 * den <= num * 256
    function automatic longint unsigned floor_root(longint unsigned num,
                                                   longint unsigned den);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        rhs = 128'(num) << (2 * psd_pkg::FRAC_BITS);
        lo  = 0;
        hi  = (1 << DB) - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = 128'(mid * mid) * 128'(den);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic seg_answer_t predict_distance(seg_query_t q);
        seg_answer_t r;
        longint bx, by, ax, ay, len2, dot, cr;
        bx = longint'($signed(q.ex)) - longint'($signed(q.sx));
        by = longint'($signed(q.ey)) - longint'($signed(q.sy));
        ax = longint'($signed(q.px)) - longint'($signed(q.sx));
        ay = longint'($signed(q.py)) - longint'($signed(q.sy));
        r  = '0;
        if (bx == 0 && by == 0)
        begin
            r.degen    = 1'b1;
            r.dist_val = DB'(floor_root(ax * ax + ay * ay, 1));
        end
        else
        begin
            len2 = bx * bx + by * by;
            dot  = bx * ax + by * ay;
            if (dot < 0 || dot > len2)
                r.oor = 1'b1;
            else
            begin
                cr = by * ax - bx * ay;
                if (cr < 0)
                    cr = -cr;
                r.dist_val = DB'(floor_root(cr * cr, len2));
            end
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return {1'b0, {(CW-1){1'b1}}};
        if (sel == 1)
            return {1'b1, {(CW-1){1'b0}}};
        if (sel < 5)
            return CW'($urandom_range(0, 40) - 20);
        return CW'($urandom);
    endfunction

    task automatic add_query(int px, int py, int sx, int sy, int ex, int ey);
        seg_query_t q;
        q = '{CW'(px), CW'(py), CW'(sx), CW'(sy), CW'(ex), CW'(ey)};
        pending_q.push_back(q);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    // stimulus
    initial
    begin
        seg_query_t q;
        int         k;
        err_count = 0;
        stim_done = 1'b0;
        add_query(0, 0, 0, 0, 0, 0);
        add_query(2047, 2047, -2048, -2048, -2048, -2048);
        add_query(-2048, 2047, 2047, -2048, 2047, -2048);
        add_query(0, 5, -10, 0, 10, 0);
        add_query(-10, 7, -10, 0, 10, 0);
        add_query(10, -7, -10, 0, 10, 0);
        add_query(-11, 0, -10, 0, 10, 0);
        add_query(11, 3, -10, 0, 10, 0);
        add_query(-2048, 2047, -2048, -2048, 2047, 2047);
        add_query(2047, -2048, -2048, -2048, 2047, 2047);
        add_query(0, -2048, -2048, 2047, 2047, 2047);
        add_query(-2048, 0, 2047, -2048, 2047, 2047);
        add_query(1, 1, 0, 0, 3, 1);
        add_query(2047, 2047, 2047, 2047, -2048, -2048);
        add_query(-2048, -2048, 2047, 2047, -2048, -2048);
        add_query(100, 3, 0, 0, 200, 0);
        for (k = 0; k < NUM_RAND; k++)
        begin
            q.sx = rand_coord();
            q.sy = rand_coord();
            if ($urandom_range(0, 9) == 0)
            begin
                q.ex = q.sx;
                q.ey = q.sy;
            end
            else
            begin
                q.ex = rand_coord();
                q.ey = rand_coord();
            end
            // bias toward points that project inside the segment
            if ($urandom_range(0, 2) != 0)
            begin
                q.px = CW'((int'($signed(q.sx)) + int'($signed(q.ex))) / 2
                           + int'($urandom_range(0, 60)) - 30);
                q.py = CW'((int'($signed(q.sy)) + int'($signed(q.ey))) / 2
                           + int'($urandom_range(0, 60)) - 30);
            end
            else
            begin
                q.px = rand_coord();
                q.py = rand_coord();
            end
            pending_q.push_back(q);
        end
        stim_done = 1'b1;
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && pending_q.size() == 0 && !in_valid &&
                 answer_q.size() == 0))
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // driver: one transfer per acceptance, random idle outside a calm window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            point_x  <= '0;
            point_y  <= '0;
            start_x  <= '0;
            start_y  <= '0;
            end_x    <= '0;
            end_y    <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                answer_q.push_back(predict_distance(
                    '{point_x, point_y, start_x, start_y, end_x, end_y}));
            if (pending_q.size() > 0 &&
                ((cycle_count > 300 && cycle_count < 600) ||
                 $urandom_range(0, 99) >= 13))
            begin
                seg_query_t q;
                q = pending_q.pop_front();
                in_valid <= 1'b1;
                point_x  <= q.px;
                point_y  <= q.py;
                start_x  <= q.sx;
                start_y  <= q.sy;
                end_x    <= q.ex;
                end_y    <= q.ey;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            seg_answer_t want;
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("unexpected transfer", 1, 0);
                else
                begin
                    want = answer_q.pop_front();
                    if (dist_q4 !== want.dist_val)
                        report_mismatch("dist_q4", dist_q4, want.dist_val);
                    if (off_segment !== want.oor)
                        report_mismatch("off_segment", off_segment, want.oor);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                end
            end
            out_stall <= !(cycle_count > 300 && cycle_count < 600) &&
                         ($urandom_range(0, 99) < 13);
        end
    end

endmodule

/* files.f */
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_root_cell.sv
hdl/point_segment_distance.sv
hdl/psd_checker.sv
verif/point_segment_distance_tb.sv
